FILE: rtl/core/cdrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing copy-request queue package
// Word types for the request and response channels, the entry layout held
// in the entry memory, and the operation codes.
// ----------------------------------------------------------------------------
package cdrq_pkg;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   typedef struct packed {
      logic        op;
      logic [23:0] source_address;
      logic [15:0] dest_address;
      logic [15:0] length;
   } req_type;

   typedef struct packed {
      logic [23:0] out_source;
      logic [15:0] out_dest;
      logic [15:0] out_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] source;
      logic [15:0] dest;
      logic [15:0] length;
   } entry_type;

endpackage

FILE: rtl/core/cdrq_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one read port; the read data is registered, so it is
// available in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module cdrq_entry_ram
   import cdrq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  entry_type                              wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output entry_type                              rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cdrq_key_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Destination key match
// Holds the destination key of every entry in its own register and compares
// all held keys against a probe in parallel, reporting the oldest match.
// ----------------------------------------------------------------------------
module cdrq_key_match
   import cdrq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   key_wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] key_wr_addr,
   input  logic [15:0]                            key_wr_data,
   input  logic [$clog2(DEPTH + 1)-1:0]           entry_count,
   input  logic [15:0]                            probe,
   output logic                                   hit,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] hit_index
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [15:0]      key_ff [DEPTH];
   logic [DEPTH-1:0] match;

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_ff[key_wr_addr] <= key_wr_data;
      end
   end

   // Only entries below the fill count take part in the compare.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = (CntW'(i) < entry_count) && (key_ff[i] == probe);
      end
   end

   // Lowest index wins, being the oldest entry.
   always_comb begin
      hit       = 1'b0;
      hit_index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit       = 1'b1;
            hit_index = IdxW'(i);
         end
      end
   end

endmodule

FILE: rtl/core/coalescing_dma_request_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing copy-request queue, top level
// Queues copy requests, merging requests to the same destination, and
// hands the whole queue out newest first on a flush.
// ----------------------------------------------------------------------------
// Usage.
// Request words arrive on the req_ channel and are taken at a clock edge
// where req_valid is high and req_stall is low. An enqueue word is
// registered on acceptance, and in the next cycle its destination is
// compared against every held key and the entry memory is written, either
// over the oldest matching entry or as a new entry at the tail. When the
// queue is full and no key matches, the request is dropped silently.
// An enqueue produces no response word.
// A flush word reads the entries from newest to oldest out of the entry
// memory, one read per response word; each response sits in an output
// register until taken. The final word of a flush has last set.
// A flush of an empty queue produces nothing.
// While rsp_stall is high the output register holds its word and the flush
// waits; the request side stays stalled until the flush has finished.
// Reset empties the queue; the entry memory is not cleared, since only
// entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module coalescing_dma_request_queue_top
   import cdrq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ENQ   = 2'd1;
   localparam logic [1:0] ST_FREAD = 2'd2;
   localparam logic [1:0] ST_FWAIT = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdxW-1:0] ptr_ff, ptr_in;
   req_type         hold_ff, hold_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic            out_free;
   logic            hit;
   logic [IdxW-1:0] hit_index;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_data;
   logic            key_wr_en;
   logic            rd_en;
   entry_type       rd_data;
   logic [CntW-1:0] count_m1;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_m1   = count_ff - CntW'(1);

   cdrq_key_match #(
      .DEPTH(DEPTH)
   ) u_key_match (
      .clock       (clock),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (wr_addr),
      .key_wr_data (hold_ff.dest_address),
      .entry_count (count_ff),
      .probe       (hold_ff.dest_address),
      .hit         (hit),
      .hit_index   (hit_index)
   );

   cdrq_entry_ram #(
      .DEPTH(DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      key_wr_en    = 1'b0;
      wr_addr      = hit_index;
      wr_data      = '{source: hold_ff.source_address,
                       dest:   hold_ff.dest_address,
                       length: hold_ff.length};
      rd_en        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.op == OP_ENQUEUE) begin
                  hold_in  = req_data;
                  state_in = ST_ENQ;
               end else if (count_ff != '0) begin
                  ptr_in   = count_m1[IdxW-1:0];
                  state_in = ST_FREAD;
               end
            end
         end
         ST_ENQ: begin
            // A matching key rewrites that entry in place; otherwise append
            // at the tail unless the queue is full.
            if (hit) begin
               wr_en = 1'b1;
            end else if (count_ff != CntW'(DEPTH)) begin
               wr_en     = 1'b1;
               key_wr_en = 1'b1;
               wr_addr   = count_ff[IdxW-1:0];
               count_in  = count_ff + CntW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_FREAD: begin
            rd_en    = 1'b1;
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_source: rd_data.source,
                                out_dest:   rd_data.dest,
                                out_length: rd_data.length,
                                last:       (ptr_ff == '0)};
               if (ptr_ff == '0) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - IdxW'(1);
                  state_in = ST_FREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
